@@ hw/rtl/gip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gip_pkg: shared types and constants for the header parser
// Beat payload structs, field widths and reset values used by the parser
// core and the top level.
// ----------------------------------------------------------------------------
package gip_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned LEN_W           = 28;
    localparam int unsigned HDR_BYTES_W     = 4;
    localparam int unsigned VCNT_W          = 3;
    localparam int unsigned MAX_VARINT_DEF  = 4;

    localparam logic [BYTE_W-1:0]      CHUNK_MASK_RESET = 8'h80;
    localparam logic [HDR_BYTES_W-1:0] MIN_HDR_BYTES    = 4'd4;
    localparam logic [HDR_BYTES_W-1:0] MAX_BYTE_INDEX   = 4'd15;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              packet_end;
    } t_in_beat;

    typedef struct packed {
        logic                   header_ok;
        logic [BYTE_W-1:0]      command_code;
        logic [BYTE_W-1:0]      option_bits;
        logic [BYTE_W-1:0]      sequence_number;
        logic [LEN_W-1:0]       payload_length;
        logic [HDR_BYTES_W-1:0] header_bytes;
    } t_out_beat;

endpackage

@@ hw/rtl/gip_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gip_header_parser: streaming link packet header decoder
// Takes packet bytes one beat at a time and produces one header result per
// packet: command, options, sequence, payload length varint, header length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one packet byte per beat, packet_end set on the last byte.
//   Output channel: one result beat per packet, on the byte that ends the
//   header (length varint, or chunk offset varint when an option bit in
//   i_cfg_data's mask is set), or on the last byte if the packet ends first.
//   header_ok is low and all fields zero for packets under four bytes.
//   Latency: the result is valid the cycle after the byte that produces it.
//   Throughput: one byte per cycle unless stalled; parse state update and
//   result assembly are combinational between the byte and result register.
//   Stall: the output register holds a waiting result; input is stalled only
//   while that register is full and the receiver stalls.
//   Reset: parse state clears to the start of a packet, the output register
//   empties and the chunk option mask returns to 0x80. Write the mask only
//   while no packet is in flight.
// ----------------------------------------------------------------------------
module gip_header_parser import gip_pkg::*; #(
    parameter int unsigned MAX_VARINT_BYTES = MAX_VARINT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    logic              r_out_valid;
    t_out_beat         r_out;
    logic [BYTE_W-1:0] r_chunk_mask;

    logic              in_accept;
    logic              emit;
    t_out_beat         result;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    gip_parse #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_beat       (i_in),
        .i_chunk_mask (r_chunk_mask),
        .o_emit       (emit),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_mask <= CHUNK_MASK_RESET;
        end else if (i_cfg_we) begin
            r_chunk_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            // drop the beat once taken
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_out <= result;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input accepted while result is stuck");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.header_ok |-> o_out.header_bytes >= MIN_HDR_BYTES)
        else $error("good header shorter than four bytes");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.header_ok |-> o_out.payload_length == '0 &&
            o_out.header_bytes == '0 && o_out.command_code == '0)
        else $error("short packet result carries data");

endmodule

@@ hw/rtl/gip_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gip_parse: per-byte header parse state
// Holds the fixed header bytes, the length varint accumulator and the phase,
// and flags the byte on which the single header result is produced.
// ----------------------------------------------------------------------------
module gip_parse import gip_pkg::*; #(
    parameter int unsigned MAX_VARINT_BYTES = MAX_VARINT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_beat          i_beat,
    input  logic [BYTE_W-1:0] i_chunk_mask,
    output logic              o_emit,
    output t_out_beat         o_result
);

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_LEN,
        PH_CHUNK,
        PH_PAYLOAD
    } t_phase;

    localparam logic [VCNT_W-1:0] VCNT_MAX = VCNT_W'(MAX_VARINT_BYTES);

    t_phase                 r_phase,    n_phase;
    logic [HDR_BYTES_W-1:0] r_idx,      n_idx;
    logic [VCNT_W-1:0]      r_vcnt,     n_vcnt;
    logic [LEN_W-1:0]       r_len,      n_len;
    logic [BYTE_W-1:0]      r_cmd,      n_cmd;
    logic [BYTE_W-1:0]      r_opt,      n_opt;
    logic [BYTE_W-1:0]      r_seq,      n_seq;
    logic                   r_emitted,  n_emitted;

    logic [VCNT_W-1:0]      vcnt_inc;
    logic                   varint_done;
    logic [5:0]             shamt;
    logic [LEN_W+6:0]       len_part;
    logic [HDR_BYTES_W-1:0] consumed;
    logic                   emit;

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_vcnt    = r_vcnt;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_opt     = r_opt;
        n_seq     = r_seq;
        n_emitted = r_emitted;
        emit      = 1'b0;

        vcnt_inc    = r_vcnt + VCNT_W'(1);
        varint_done = !i_beat.data_byte[7] || (vcnt_inc >= VCNT_MAX);
        shamt       = {r_vcnt, 3'b000} - {3'b000, r_vcnt};
        len_part    = {{(LEN_W){1'b0}}, i_beat.data_byte[6:0]} << shamt;

        case (r_phase)
            PH_FIXED: begin
                if (r_idx == 4'd0) begin
                    n_cmd = i_beat.data_byte;
                end else if (r_idx == 4'd1) begin
                    n_opt = i_beat.data_byte;
                end else begin
                    n_seq   = i_beat.data_byte;
                    n_phase = PH_LEN;
                    n_vcnt  = '0;
                end
            end
            PH_LEN: begin
                n_len  = r_len | len_part[LEN_W-1:0];
                n_vcnt = vcnt_inc;
                if (varint_done) begin
                    n_vcnt = '0;
                    // chunk offset varint follows when an announced option bit is set
                    if ((r_opt & i_chunk_mask) != '0) begin
                        n_phase = PH_CHUNK;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        emit    = 1'b1;
                    end
                end
            end
            PH_CHUNK: begin
                n_vcnt = vcnt_inc;
                if (varint_done) begin
                    n_vcnt  = '0;
                    n_phase = PH_PAYLOAD;
                    emit    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        consumed = (r_idx == MAX_BYTE_INDEX) ? MAX_BYTE_INDEX : r_idx + 4'd1;

        if (i_beat.packet_end) begin
            emit = 1'b1;
        end
        if (r_emitted) begin
            emit = 1'b0;
        end
        if (emit) begin
            n_emitted = 1'b1;
        end
        n_idx = consumed;

        // a packet's last byte drops all packet state
        if (i_beat.packet_end) begin
            n_phase   = PH_FIXED;
            n_idx     = '0;
            n_vcnt    = '0;
            n_len     = '0;
            n_cmd     = '0;
            n_opt     = '0;
            n_seq     = '0;
            n_emitted = 1'b0;
        end
    end

    // From the fourth byte on the three fixed header bytes are all held.
    always_comb begin
        o_emit = emit;
        if (consumed >= MIN_HDR_BYTES) begin
            o_result.header_ok       = 1'b1;
            o_result.command_code    = r_cmd;
            o_result.option_bits     = r_opt;
            o_result.sequence_number = r_seq;
            o_result.payload_length  = (r_phase == PH_LEN) ? r_len | len_part[LEN_W-1:0]
                                                            : r_len;
            o_result.header_bytes    = consumed;
        end else begin
            o_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIXED;
            r_idx     <= '0;
            r_vcnt    <= '0;
            r_len     <= '0;
            r_cmd     <= '0;
            r_opt     <= '0;
            r_seq     <= '0;
            r_emitted <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_vcnt    <= n_vcnt;
            r_len     <= n_len;
            r_cmd     <= n_cmd;
            r_opt     <= n_opt;
            r_seq     <= n_seq;
            r_emitted <= n_emitted;
        end
    end

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt < VCNT_MAX)
        else $error("varint byte count reached its limit");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted |-> !emit)
        else $error("second header result in one packet");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_beat.packet_end |=> r_idx == '0 && !r_emitted && r_phase == PH_FIXED)
        else $error("packet state not cleared after last byte");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gip_header_parser
// Feeds packet bytes over the valid/stall input channel and compares every
// header result field by field against a cycle-free decoder kept in the bench.
// A short directed table covers short packets, overlong and cut-off varints and
// the chunk offset path; random well-formed, truncated and noise packets follow
// under several chunk option masks, with random idling on both channels and one
// long receiver hold-off that backs the parser up into its input.
// ----------------------------------------------------------------------------
module tb_top import gip_pkg::*; ();

    typedef enum logic [1:0] {
        ST_FIXED,
        ST_LENGTH,
        ST_CHUNK,
        ST_PAYLOAD
    } t_parse_st;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_beat          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_beat         o_out;
    logic              i_cfg_we    = 1'b0;
    logic [BYTE_W-1:0] i_cfg_data  = '0;

    // bench-side decoder state
    logic [BYTE_W-1:0] chunk_mask = CHUNK_MASK_RESET;
    t_parse_st         pr_state   = ST_FIXED;
    int unsigned       pr_idx     = 0;
    int unsigned       pr_vcnt    = 0;
    logic [LEN_W-1:0]  pr_len     = '0;
    logic [BYTE_W-1:0] pr_cmd     = '0;
    logic [BYTE_W-1:0] pr_opt     = '0;
    logic [BYTE_W-1:0] pr_seq     = '0;
    logic              pr_done    = 1'b0;

    t_out_beat   pending_hdrs[$];
    t_in_beat    pkt_q[$];
    int unsigned err_count    = 0;
    int unsigned hdrs_checked = 0;
    int unsigned bytes_fed    = 0;
    int unsigned masks_used   = 0;
    int unsigned idle_pct     = 15;
    int unsigned stall_pct    = 15;
    int unsigned stall_left   = 0;
    logic        quiet        = 1'b0;
    logic        hold_done    = 1'b0;

    gip_header_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic flag_mismatch(input string msg);
        if (err_count < 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic t_out_beat hdr(input logic ok, input logic [7:0] cmd,
                                      input logic [7:0] opt, input logic [7:0] seq,
                                      input logic [LEN_W-1:0] len,
                                      input logic [HDR_BYTES_W-1:0] nbytes);
        return {ok, cmd, opt, seq, len, nbytes};
    endfunction

    function automatic t_dir_row row(input logic [7:0] b, input logic last,
                                     input logic typed = 1'b0,
                                     input t_out_beat want = '0);
        return {b, last, typed, want};
    endfunction

    // Append one beat to the packet being built.
    function automatic void enqueue_byte(input t_in_beat beat);
        pkt_q.insert(pkt_q.size(), beat);
    endfunction

    // Append one header to the expected results.
    function automatic void expect_hdr(input t_out_beat h);
        pending_hdrs.insert(pending_hdrs.size(), h);
    endfunction

    // Decode one accepted byte; emit is set when the byte closes a header.
    task automatic decode_header_byte(input logic [7:0] b, input logic last,
                                      output logic emit, output t_out_beat res);
        logic [34:0] part;
        logic        vdone;
        int unsigned used;
        emit = 1'b0;
        res  = '0;
        case (pr_state)
            ST_FIXED: begin
                if (pr_idx == 0) begin
                    pr_cmd = b;
                end else if (pr_idx == 1) begin
                    pr_opt = b;
                end else begin
                    pr_seq   = b;
                    pr_state = ST_LENGTH;
                    pr_vcnt  = 0;
                end
            end
            ST_LENGTH: begin
                part   = {28'd0, b[6:0]} << (7 * pr_vcnt);
                pr_len = pr_len | part[LEN_W-1:0];
                pr_vcnt++;
                vdone = !b[7] || (pr_vcnt >= MAX_VARINT_DEF);
                if (vdone) begin
                    pr_vcnt = 0;
                    // mask is sampled as the length varint closes
                    if ((pr_opt & chunk_mask) != 0) begin
                        pr_state = ST_CHUNK;
                    end else begin
                        pr_state = ST_PAYLOAD;
                        emit     = 1'b1;
                    end
                end
            end
            ST_CHUNK: begin
                pr_vcnt++;
                vdone = !b[7] || (pr_vcnt >= MAX_VARINT_DEF);
                if (vdone) begin
                    pr_vcnt  = 0;
                    pr_state = ST_PAYLOAD;
                    emit     = 1'b1;
                end
            end
            default: begin
            end
        endcase
        used = (pr_idx >= MAX_BYTE_INDEX) ? MAX_BYTE_INDEX : pr_idx + 1;
        if (last && !pr_done) emit = 1'b1;
        if (pr_done) emit = 1'b0;
        if (emit) begin
            if (used >= MIN_HDR_BYTES) begin
                res = hdr(1'b1, pr_cmd, pr_opt, pr_seq, pr_len, used[HDR_BYTES_W-1:0]);
            end
            pr_done = 1'b1;
        end
        pr_idx = used;
        if (last) begin
            pr_state = ST_FIXED;
            pr_idx   = 0;
            pr_vcnt  = 0;
            pr_len   = '0;
            pr_cmd   = '0;
            pr_opt   = '0;
            pr_seq   = '0;
            pr_done  = 1'b0;
        end
    endtask

    // Offer one beat, optionally after an idle burst, and hold it until taken.
    task automatic push_byte(input t_in_beat beat, output logic emit,
                             output t_out_beat res);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        decode_header_byte(beat.data_byte, beat.packet_end, emit, res);
        bytes_fed++;
    endtask

    task automatic add_varint();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(1, MAX_VARINT_DEF);
        for (int unsigned i = 0; i < n; i++) begin
            b    = 8'($urandom_range(0, 255));
            b[7] = (i + 1 < n) || ($urandom_range(0, 9) == 0);
            enqueue_byte({b, 1'b0});
        end
    endtask

    // Write the mask only once the parser has drained.
    task automatic write_chunk_mask(input logic [BYTE_W-1:0] m);
        i_in_valid <= 1'b0;
        while (pending_hdrs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        chunk_mask = m;
        masks_used++;
    endtask

    // receiver: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (!hold_done && hdrs_checked >= 150) begin
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
            stall_left  <= 300;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 14);
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            hdrs_checked++;
            if (pending_hdrs.size() == 0) begin
                flag_mismatch("header result with nothing expected");
            end else begin
                want = pending_hdrs.pop_front();
                if (o_out.header_ok !== want.header_ok)
                    flag_mismatch($sformatf("header_ok got %0b want %0b",
                                            o_out.header_ok, want.header_ok));
                if (o_out.command_code !== want.command_code)
                    flag_mismatch($sformatf("command_code got %0h want %0h",
                                            o_out.command_code, want.command_code));
                if (o_out.option_bits !== want.option_bits)
                    flag_mismatch($sformatf("option_bits got %0h want %0h",
                                            o_out.option_bits, want.option_bits));
                if (o_out.sequence_number !== want.sequence_number)
                    flag_mismatch($sformatf("sequence_number got %0h want %0h",
                                            o_out.sequence_number, want.sequence_number));
                if (o_out.payload_length !== want.payload_length)
                    flag_mismatch($sformatf("payload_length got %0h want %0h",
                                            o_out.payload_length, want.payload_length));
                if (o_out.header_bytes !== want.header_bytes)
                    flag_mismatch($sformatf("header_bytes got %0d want %0d",
                                            o_out.header_bytes, want.header_bytes));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d headers still pending", pending_hdrs.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_dir_row    dir_tbl[$];
        t_out_beat   res;
        logic        emit;
        logic [7:0]  opt;
        logic [7:0]  m;
        int unsigned kind;
        int unsigned n;
        int unsigned phase_bytes;
        int unsigned pkt_count;

        dir_tbl = '{
            // one-byte and three-byte packets are too short
            row(8'hFF, 1'b1, 1'b1, '0),
            row(8'h00, 1'b0), row(8'h80, 1'b0), row(8'h7F, 1'b1, 1'b1, '0),
            // smallest complete header
            row(8'hFF, 1'b0), row(8'h00, 1'b0), row(8'hFF, 1'b0),
            row(8'h7F, 1'b1, 1'b1, hdr(1'b1, 8'hFF, 8'h00, 8'hFF, 28'h7F, 4'd4)),
            // overlong length varint, all ones
            row(8'h00, 1'b0), row(8'h7F, 1'b0), row(8'h00, 1'b0),
            row(8'hFF, 1'b0), row(8'hFF, 1'b0), row(8'hFF, 1'b0),
            row(8'hFF, 1'b1, 1'b1, hdr(1'b1, 8'h00, 8'h7F, 8'h00, 28'hFFFFFFF, 4'd7)),
            // packet ends right after the length while a chunk offset is due
            row(8'h5A, 1'b0), row(8'h80, 1'b0), row(8'hA5, 1'b0), row(8'h00, 1'b1),
            // chunk offset cut off by the packet end
            row(8'h3C, 1'b0), row(8'hC3, 1'b0), row(8'h01, 1'b0),
            row(8'h81, 1'b0), row(8'h7F, 1'b0), row(8'h80, 1'b1)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            push_byte(dir_tbl[i].beat, emit, res);
            if (dir_tbl[i].typed) begin
                expect_hdr(dir_tbl[i].want);
            end else if (emit) begin
                expect_hdr(res);
            end
        end

        pkt_count = 0;
        for (int unsigned p = 0; p < 9; p++) begin
            case (p)
                0: m = 8'h00;
                1: m = 8'hFF;
                2: m = 8'h01;
                3: m = 8'h80;
                4: m = 8'h7F;
                default: m = 8'($urandom_range(0, 255));
            endcase
            write_chunk_mask(m);
            quiet = (p == 8);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 8;
                default: idle_pct = 25;
            endcase
            stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
            phase_bytes = 0;
            while (phase_bytes < 205) begin
                pkt_q.delete();
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    // noise: random bytes, packet ends anywhere
                    n = $urandom_range(1, 8);
                    for (int unsigned i = 0; i < n; i++)
                        enqueue_byte({8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 3) == 0)});
                end else begin
                    opt = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0) opt = opt & ~chunk_mask;
                    enqueue_byte({8'($urandom_range(0, 255)), 1'b0});
                    enqueue_byte({opt, 1'b0});
                    enqueue_byte({8'($urandom_range(0, 255)), 1'b0});
                    add_varint();
                    if ((opt & chunk_mask) != 0) add_varint();
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(0, 5);
                    for (int unsigned i = 0; i < n; i++)
                        enqueue_byte({8'($urandom_range(0, 255)), 1'b0});
                    // truncate at a random byte, which can cut the header short
                    if (kind < 30) begin
                        n = $urandom_range(1, pkt_q.size());
                        while (pkt_q.size() > n) void'(pkt_q.pop_back());
                    end
                end
                pkt_q[pkt_q.size() - 1].packet_end = 1'b1;
                foreach (pkt_q[i]) begin
                    push_byte(pkt_q[i], emit, res);
                    if (emit) expect_hdr(res);
                end
                phase_bytes += pkt_q.size();
                pkt_count++;
            end
        end
        i_in_valid <= 1'b0;

        while (pending_hdrs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("fed %0d bytes in %0d random packets plus directed rows", bytes_fed,
                 pkt_count);
        $display("checked %0d headers across %0d chunk mask settings, %0d errors",
                 hdrs_checked, masks_used, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ gip_header_parser.f @@
hw/rtl/gip_pkg.sv
hw/rtl/gip_parse.sv
hw/rtl/gip_header_parser.sv
sim/tb_top.sv
